[hw/rtl/best_fit_segment_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the best-fit segment allocator
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define BFSA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bfsa_pkg.sv]
// ----------------------------------------------------------------------------
// bfsa_pkg
// Types, codes and widths shared by the segment table cells and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfsa_pkg;

    // address space and field widths
    localparam int ADDR_BITS = 12;
    localparam int LEN_W     = ADDR_BITS + 1;
    // index and count widths cover the largest supported table (256 entries)
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;

    localparam logic [LEN_W-1:0] MEM_LIMIT = LEN_W'(1) << ADDR_BITS;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_COMPACT = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_NORANK  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    // table commands broadcast to every cell
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_INIT    = 4'd1;
    localparam logic [3:0] CMD_TAKE    = 4'd2;
    localparam logic [3:0] CMD_SPLIT   = 4'd3;
    localparam logic [3:0] CMD_RELEASE = 4'd4;
    localparam logic [3:0] CMD_MERGE   = 4'd5;
    localparam logic [3:0] CMD_SWAP    = 4'd6;
    localparam logic [3:0] CMD_TAIL    = 4'd7;

    // one table entry
    typedef struct packed {
        logic                 used;
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     len;
    } entry_t;

    // table command
    typedef struct packed {
        logic [3:0]           code;
        logic [IDX_W-1:0]     idx;
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     len2;
    } cmd_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                 live;
        logic                 rebase;
        logic                 best_ok;
        logic [IDX_W-1:0]     best_idx;
        logic [LEN_W-1:0]     best_len;
        logic [ADDR_BITS-1:0] best_base;
        logic [CNT_W-1:0]     seen;
        logic                 hit;
        logic [IDX_W-1:0]     hit_idx;
        logic [ADDR_BITS-1:0] hit_base;
        logic [LEN_W-1:0]     hit_len;
        logic                 left_free;
        logic                 right_free;
        logic                 prev_free;
        logic                 prev_hit;
        logic [LEN_W-1:0]     cursor;
        logic [CNT_W-1:0]     used_cnt;
    } scan_t;

endpackage

[hw/rtl/bfsa_cell.sv]
// ----------------------------------------------------------------------------
// bfsa_cell
// One segment table entry; applies broadcast commands, trades entries with
// its neighbors and updates the scan token as it passes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfsa_cell #(
    parameter int IDX = 0,
    parameter int NUM = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  bfsa_pkg::cmd_t          cmd,
    input  logic [bfsa_pkg::CNT_W-1:0] count,
    input  logic [bfsa_pkg::LEN_W-1:0] req,
    input  logic [bfsa_pkg::CNT_W-1:0] rank,
    input  bfsa_pkg::entry_t        left_ent,
    input  bfsa_pkg::entry_t        right_ent,
    input  bfsa_pkg::scan_t         wave_in,
    output bfsa_pkg::entry_t        ent,
    output bfsa_pkg::scan_t         wave_out
);

    import bfsa_pkg::*;

    localparam logic [CNT_W-1:0] MY_POS    = CNT_W'(IDX);
    localparam logic             HAS_LEFT  = (IDX > 0);
    localparam logic             HAS_RIGHT = (IDX < NUM - 1);
    localparam logic             MY_PAR    = ((IDX % 2) == 1);

    entry_t           entry_reg;
    entry_t           entry_next;
    scan_t            wave_reg;
    scan_t            wave_next;
    logic             is_valid;
    logic             right_valid;
    logic             my_used;
    logic             my_free;
    logic             right_used;
    logic             rank_match;
    logic [CNT_W-1:0] cmd_pos;

    assign is_valid    = (MY_POS < count);
    assign right_valid = ((MY_POS + CNT_W'(1)) < count);
    assign my_used     = is_valid && entry_reg.used;
    assign my_free     = is_valid && !entry_reg.used;
    assign right_used  = right_valid && right_ent.used;
    assign cmd_pos     = CNT_W'(cmd.idx);
    assign rank_match  = my_used && !wave_in.hit && (wave_in.seen == rank);

    // entry update
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.code)
            CMD_INIT:
            begin
                entry_next.used = 1'b0;
                if (IDX == 0)
                begin
                    entry_next.base = '0;
                    entry_next.len  = cmd.len;
                end
            end
            CMD_TAKE:
            begin
                if (cmd_pos == MY_POS)
                    entry_next.used = 1'b1;
            end
            CMD_SPLIT:
            begin
                if (cmd_pos == MY_POS)
                begin
                    entry_next.used = 1'b1;
                    entry_next.len  = cmd.len;
                end
                else if (cmd_pos + CNT_W'(1) == MY_POS)
                begin
                    entry_next.used = 1'b0;
                    entry_next.base = cmd.base;
                    entry_next.len  = cmd.len2;
                end
                else if (HAS_LEFT && (MY_POS > cmd_pos + CNT_W'(1)))
                    entry_next = left_ent;
            end
            CMD_RELEASE:
            begin
                if (cmd_pos == MY_POS)
                    entry_next.used = 1'b0;
            end
            CMD_MERGE:
            begin
                if (cmd_pos == MY_POS)
                    entry_next.len = entry_reg.len + right_ent.len;
                else if (HAS_RIGHT && (MY_POS > cmd_pos))
                    entry_next = right_ent;
            end
            CMD_SWAP:
            begin
                // odd-even pass: used entries bubble toward the front
                if (MY_PAR == cmd.idx[0])
                begin
                    if (HAS_RIGHT && !my_used && right_used)
                        entry_next = right_ent;
                end
                else if (HAS_LEFT && !left_ent.used && my_used)
                    entry_next = left_ent;
            end
            CMD_TAIL:
            begin
                if (cmd_pos == MY_POS)
                begin
                    entry_next.used = 1'b0;
                    entry_next.base = cmd.base;
                    entry_next.len  = cmd.len2;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
        // compaction: used entries take the running base as the token passes
        if (wave_in.live && wave_in.rebase && my_used)
            entry_next.base = wave_in.cursor[ADDR_BITS-1:0];
    end

    // scan token update
    always_comb
    begin
        wave_next = wave_in;
        if (my_free && (entry_reg.len >= req) &&
            (!wave_in.best_ok || (entry_reg.len < wave_in.best_len)))
        begin
            wave_next.best_ok   = 1'b1;
            wave_next.best_idx  = IDX_W'(IDX);
            wave_next.best_len  = entry_reg.len;
            wave_next.best_base = entry_reg.base;
        end
        if (rank_match)
        begin
            wave_next.hit       = 1'b1;
            wave_next.hit_idx   = IDX_W'(IDX);
            wave_next.hit_base  = entry_reg.base;
            wave_next.hit_len   = entry_reg.len;
            wave_next.left_free = wave_in.prev_free;
        end
        else if (my_used && !wave_in.hit)
            wave_next.seen = wave_in.seen + CNT_W'(1);
        if (wave_in.prev_hit)
            wave_next.right_free = my_free;
        wave_next.prev_hit  = rank_match;
        wave_next.prev_free = my_free;
        if (my_used)
        begin
            wave_next.cursor   = wave_in.cursor + entry_reg.len;
            wave_next.used_cnt = wave_in.used_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.used <= 1'b0;
            entry_reg.base <= '0;
            entry_reg.len  <= (IDX == 0) ? MEM_LIMIT : '0;
            wave_reg       <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            wave_reg  <= wave_next;
        end
    end

    assign ent      = entry_reg;
    assign wave_out = wave_reg;

endmodule

[hw/rtl/best_fit_segment_allocator.sv]
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// Best-fit allocator over an address-ordered segment table with coalescing
// and compaction.
// ----------------------------------------------------------------------------
// The table is a row of MAX_SEGMENTS cells; a scan token walks the row one
// cell per clock, and a lookup ends when it leaves the last cell. Allocate that
// fits: a scan, then the take or split. Free: a scan, the release, then a merge
// with each free neighbor. Compact: MAX_SEGMENTS odd-even swap passes, one
// rebase scan and the tail write. Allocate that needs a compaction: a scan, the
// compaction and a second scan. A zero request or an unused opcode goes
// straight to the result. One operation is worked at a time; a finished result
// waits in the output register while the next beat is taken. A write to the
// memory size register reloads the table with one free segment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "best_fit_segment_allocator_defines.svh"

module best_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: req_size, free_rank, zero fill
    input  logic [(((bfsa_pkg::LEN_W + ((MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1))
                    + 7) / 8) * 8 - 1:0] s_tdata,
    // tuser: op
    input  logic [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status, seg_base, seg_len, compacted, free_units, tail_free, zero fill
    output logic [((2 + bfsa_pkg::ADDR_BITS + 3 * bfsa_pkg::LEN_W + 1 + 7) / 8) * 8 - 1:0]
                        m_tdata
);

    import bfsa_pkg::*;

    localparam int RANK_W   = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int S_DATA_W = ((LEN_W + RANK_W + 7) / 8) * 8;
    localparam int OUT_W    = 2 + ADDR_BITS + 3 * LEN_W + 1;
    localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] NUM_C = CNT_W'(MAX_SEGMENTS);

    localparam logic REG_TOTAL = 1'b0;

    // sequencer states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SCAN    = 4'd1;
    localparam logic [3:0] ST_APPLY   = 4'd2;
    localparam logic [3:0] ST_RELEASE = 4'd3;
    localparam logic [3:0] ST_MERGE_R = 4'd4;
    localparam logic [3:0] ST_MERGE_L = 4'd5;
    localparam logic [3:0] ST_SORT    = 4'd6;
    localparam logic [3:0] ST_REBASE  = 4'd7;
    localparam logic [3:0] ST_TAIL    = 4'd8;
    localparam logic [3:0] ST_DONE    = 4'd9;

    logic [3:0]           state_reg,   state_next;
    logic [1:0]           op_reg,      op_next;
    logic [LEN_W-1:0]     req_reg,     req_next;
    logic [CNT_W-1:0]     rank_reg,    rank_next;
    logic                 comp_reg,    comp_next;
    logic [LEN_W-1:0]     total_reg,   total_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic [LEN_W-1:0]     free_reg,    free_next;
    logic                 launch_reg,  launch_next;
    logic [CNT_W-1:0]     round_reg,   round_next;
    logic [IDX_W-1:0]     k_reg,       k_next;
    logic [ADDR_BITS-1:0] kbase_reg,   kbase_next;
    logic [LEN_W-1:0]     klen_reg,    klen_next;
    logic [LEN_W-1:0]     rest_reg,    rest_next;
    logic                 lfree_reg,   lfree_next;
    logic                 rfree_reg,   rfree_next;
    logic [LEN_W-1:0]     cur_reg,     cur_next;
    logic [CNT_W-1:0]     wcnt_reg,    wcnt_next;
    logic [1:0]           rstat_reg,   rstat_next;
    logic [ADDR_BITS-1:0] rbase_reg,   rbase_next;
    logic [LEN_W-1:0]     rlen_reg,    rlen_next;
    logic [LEN_W-1:0]     rtail_reg,   rtail_next;
    logic                 out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0]  out_data_reg,  out_data_next;

    cmd_t                 cmd;
    scan_t                wave_init;
    scan_t                wave_tail;
    entry_t               ents  [MAX_SEGMENTS];
    scan_t                waves [MAX_SEGMENTS];
    logic                 cfg_write;
    logic                 s_accept;
    logic [LEN_W-1:0]     clamp_size;
    logic [LEN_W-1:0]     fit_rest;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_TOTAL);
    assign prdata    = (paddr[2] == REG_TOTAL) ? 32'(total_reg) : '0;

    always_comb
    begin
        if (pwdata == '0)
            clamp_size = LEN_W'(1);
        else if (pwdata > 32'(MEM_LIMIT))
            clamp_size = MEM_LIMIT;
        else
            clamp_size = pwdata[LEN_W-1:0];
    end

    // stream handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // scan token source
    always_comb
    begin
        wave_init        = '0;
        wave_init.live   = launch_reg;
        wave_init.rebase = (state_reg == ST_REBASE);
    end

    assign wave_tail = waves[MAX_SEGMENTS-1];
    assign fit_rest  = wave_tail.best_len - req_reg;

    // segment table
    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            entry_t left_ent;
            entry_t right_ent;
            scan_t  wave_src;
            if (g == 0)
            begin : g_first
                assign left_ent = '0;
                assign wave_src = wave_init;
            end
            else
            begin : g_mid
                assign left_ent = ents[g-1];
                assign wave_src = waves[g-1];
            end
            if (g == MAX_SEGMENTS - 1)
            begin : g_last
                assign right_ent = '0;
            end
            else
            begin : g_inner
                assign right_ent = ents[g+1];
            end
            bfsa_cell #(
                .IDX (g),
                .NUM (MAX_SEGMENTS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .count     (count_reg),
                .req       (req_reg),
                .rank      (rank_reg),
                .left_ent  (left_ent),
                .right_ent (right_ent),
                .wave_in   (wave_src),
                .ent       (ents[g]),
                .wave_out  (waves[g])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        req_next       = req_reg;
        rank_next      = rank_reg;
        comp_next      = comp_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        launch_next    = 1'b0;
        round_next     = round_reg;
        k_next         = k_reg;
        kbase_next     = kbase_reg;
        klen_next      = klen_reg;
        rest_next      = rest_reg;
        lfree_next     = lfree_reg;
        rfree_next     = rfree_reg;
        cur_next       = cur_reg;
        wcnt_next      = wcnt_reg;
        rstat_next     = rstat_reg;
        rbase_next     = rbase_reg;
        rlen_next      = rlen_reg;
        rtail_next     = rtail_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cmd            = '0;
        cmd.code       = CMD_NONE;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    op_next    = s_tuser;
                    req_next   = s_tdata[LEN_W-1:0];
                    rank_next  = CNT_W'(s_tdata[LEN_W +: RANK_W]);
                    comp_next  = 1'b0;
                    rstat_next = STAT_OK;
                    rbase_next = '0;
                    rlen_next  = '0;
                    rtail_next = '0;
                    case (s_tuser)
                        OP_ALLOC:
                        begin
                            if (s_tdata[LEN_W-1:0] == '0)
                            begin
                                rstat_next = STAT_NOSPACE;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                launch_next = 1'b1;
                                state_next  = ST_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            launch_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                        OP_COMPACT:
                        begin
                            comp_next  = 1'b1;
                            round_next = '0;
                            state_next = ST_SORT;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (wave_tail.live)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        if (wave_tail.best_ok)
                        begin
                            k_next     = wave_tail.best_idx;
                            kbase_next = wave_tail.best_base;
                            rest_next  = fit_rest;
                            if ((fit_rest != '0) && (count_reg >= NUM_C))
                            begin
                                rstat_next = STAT_FULL;
                                state_next = ST_DONE;
                            end
                            else
                                state_next = ST_APPLY;
                        end
                        else if (!comp_reg)
                        begin
                            comp_next  = 1'b1;
                            round_next = '0;
                            state_next = ST_SORT;
                        end
                        else
                        begin
                            rstat_next = STAT_NOSPACE;
                            rtail_next = free_reg;
                            state_next = ST_DONE;
                        end
                    end
                    else if (wave_tail.hit)
                    begin
                        k_next     = wave_tail.hit_idx;
                        kbase_next = wave_tail.hit_base;
                        klen_next  = wave_tail.hit_len;
                        lfree_next = wave_tail.left_free;
                        rfree_next = wave_tail.right_free;
                        state_next = ST_RELEASE;
                    end
                    else
                    begin
                        rstat_next = STAT_NORANK;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_APPLY:
            begin
                cmd.code = (rest_reg != '0) ? CMD_SPLIT : CMD_TAKE;
                cmd.idx  = k_reg;
                cmd.base = kbase_reg + req_reg[ADDR_BITS-1:0];
                cmd.len  = req_reg;
                cmd.len2 = rest_reg;
                if (rest_reg != '0)
                    count_next = count_reg + CNT_W'(1);
                free_next  = free_reg - req_reg;
                rbase_next = kbase_reg;
                rlen_next  = req_reg;
                state_next = ST_DONE;
            end
            ST_RELEASE:
            begin
                cmd.code   = CMD_RELEASE;
                cmd.idx    = k_reg;
                free_next  = free_reg + klen_reg;
                rbase_next = kbase_reg;
                rlen_next  = klen_reg;
                if (rfree_reg)
                    state_next = ST_MERGE_R;
                else if (lfree_reg)
                    state_next = ST_MERGE_L;
                else
                    state_next = ST_DONE;
            end
            ST_MERGE_R:
            begin
                // fold the free right neighbor into the released entry
                cmd.code   = CMD_MERGE;
                cmd.idx    = k_reg;
                count_next = count_reg - CNT_W'(1);
                state_next = lfree_reg ? ST_MERGE_L : ST_DONE;
            end
            ST_MERGE_L:
            begin
                // fold the released entry into the free left neighbor
                cmd.code   = CMD_MERGE;
                cmd.idx    = k_reg - IDX_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_SORT:
            begin
                cmd.code   = CMD_SWAP;
                cmd.idx    = IDX_W'(round_reg[0]);
                round_next = round_reg + CNT_W'(1);
                if (round_reg == NUM_C - CNT_W'(1))
                begin
                    launch_next = 1'b1;
                    state_next  = ST_REBASE;
                end
            end
            ST_REBASE:
            begin
                if (wave_tail.live)
                begin
                    cur_next   = wave_tail.cursor;
                    wcnt_next  = wave_tail.used_cnt;
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if ((cur_reg < total_reg) && (wcnt_reg < NUM_C))
                begin
                    cmd.code   = CMD_TAIL;
                    cmd.idx    = IDX_W'(wcnt_reg);
                    cmd.base   = cur_reg[ADDR_BITS-1:0];
                    cmd.len2   = total_reg - cur_reg;
                    count_next = wcnt_reg + CNT_W'(1);
                end
                else
                    count_next = wcnt_reg;
                if (op_reg == OP_ALLOC)
                begin
                    launch_next = 1'b1;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    rtail_next = free_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_DATA_W'({rtail_reg, free_reg, comp_reg,
                                                rlen_reg, rbase_reg, rstat_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // memory size write reloads the table
        if (cfg_write)
        begin
            total_next = clamp_size;
            count_next = CNT_W'(1);
            free_next  = clamp_size;
            cmd        = '0;
            cmd.code   = CMD_INIT;
            cmd.len    = clamp_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ALLOC;
            req_reg       <= '0;
            rank_reg      <= '0;
            comp_reg      <= 1'b0;
            total_reg     <= MEM_LIMIT;
            count_reg     <= CNT_W'(1);
            free_reg      <= MEM_LIMIT;
            launch_reg    <= 1'b0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            req_reg       <= req_next;
            rank_reg      <= rank_next;
            comp_reg      <= comp_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            launch_reg    <= launch_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        kbase_reg    <= kbase_next;
        klen_reg     <= klen_next;
        rest_reg     <= rest_next;
        lfree_reg    <= lfree_next;
        rfree_reg    <= rfree_next;
        cur_reg      <= cur_next;
        wcnt_reg     <= wcnt_next;
        rstat_reg    <= rstat_next;
        rbase_reg    <= rbase_next;
        rlen_reg     <= rlen_next;
        rtail_reg    <= rtail_next;
        out_data_reg <= out_data_next;
    end

    // checks
    `BFSA_ASSERT_NOW(a_free_within_total, free_reg <= total_reg, "free units exceed managed size")
    `BFSA_ASSERT_NOW(a_count_in_range, (count_reg != '0) && (count_reg <= NUM_C), "entry count out of range")
    `BFSA_ASSERT_NEXT(a_result_loaded, (state_reg == ST_DONE) && (!out_valid_reg || m_tready), out_valid_reg && (state_reg == ST_IDLE), "result beat not loaded")

endmodule
